// ===== rtl/sle_pkg.sv =====
// Shared types, codes and command tables for the serial line editor.
// Has no dependencies; every other file in rtl imports it.
`timescale 1ns / 1ps

package sle_pkg;

  // Longest edit line in characters.
  localparam int LINE_CAPACITY = 63;
  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

  // Only the first characters of the line can ever match a command, so only those are kept.
  localparam int PREFIX_LEN = 7;
  localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);

  localparam int CMD_COUNT = 5;
  localparam int MAX_RESULTS = 3;

  localparam logic [7:0] LED_LEVEL_RESET = 8'd64;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_FLUSH   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_LED      = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] echo_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  // All the results caused by one request; cnt of zero means none.
  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

  localparam result_t RESULT_NONE = '{
    kind: KIND_ECHO, echo_byte: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00
  };

  // Command names, in match order: LED_ON, LED_OFF, RED, GREEN, BLUE.
  localparam logic [7:0] CMD_TEXT [CMD_COUNT][PREFIX_LEN] = '{
    '{8'h4C, 8'h45, 8'h44, 8'h5F, 8'h4F, 8'h4E, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h5F, 8'h4F, 8'h46, 8'h46},
    '{8'h52, 8'h45, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h52, 8'h45, 8'h45, 8'h4E, 8'h00, 8'h00},
    '{8'h42, 8'h4C, 8'h55, 8'h45, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] CMD_LEN [CMD_COUNT] = '{3'd6, 3'd7, 3'd3, 3'd5, 3'd4};

  // Lit channels per command as {red, green, blue}.
  localparam logic [2:0] CMD_RGB [CMD_COUNT] = '{3'b111, 3'b000, 3'b100, 3'b010, 3'b001};

endpackage

// ===== rtl/sle_edit.sv =====
// Edit line state and the decode of one request into its bundle of results.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_edit
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       advance_i,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] led_level_i,
  output bundle_t    bundle_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic             too_long_q, too_long_d;
  logic [7:0]       chars_q [PREFIX_LEN];
  logic             store;

  logic             is_eol, is_erase, is_print;
  logic             hit;
  logic [2:0]       hit_rgb;
  logic [CMD_COUNT-1:0] cmd_hit;

  assign is_eol   = (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF);
  assign is_erase = (rx_byte_i == CHAR_BS) || (rx_byte_i == CHAR_DEL);
  assign is_print = (rx_byte_i >= CHAR_SPACE) && (rx_byte_i <= CHAR_TILDE);

  // Each command is compared in parallel; the names have distinct lengths.
  always_comb begin
    for (int i = 0; i < CMD_COUNT; i++) begin
      cmd_hit[i] = (len_q == LEN_W'(CMD_LEN[i]));
      for (int j = 0; j < PREFIX_LEN; j++) begin
        if ((j < int'(CMD_LEN[i])) && (chars_q[j] != CMD_TEXT[i][j])) begin
          cmd_hit[i] = 1'b0;
        end
      end
    end
    hit     = 1'b0;
    hit_rgb = 3'b000;
    for (int i = CMD_COUNT - 1; i >= 0; i--) begin
      if (cmd_hit[i]) begin
        hit     = 1'b1;
        hit_rgb = CMD_RGB[i];
      end
    end
  end

  always_comb begin
    bundle_o   = '{cnt: 2'd0, res: {MAX_RESULTS{RESULT_NONE}}};
    len_d      = len_q;
    too_long_d = too_long_q;
    store      = 1'b0;
    if (command_i == CMD_FLUSH) begin
      len_d      = '0;
      too_long_d = 1'b0;
    end else if (is_eol) begin
      bundle_o.cnt              = 2'd2;
      bundle_o.res[0].echo_byte = CHAR_CR;
      bundle_o.res[1].echo_byte = CHAR_LF;
      if (too_long_q) begin
        bundle_o.cnt         = 2'd3;
        bundle_o.res[2].kind = KIND_TOO_LONG;
      end else if (len_q != '0) begin
        bundle_o.cnt = 2'd3;
        if (hit) begin
          bundle_o.res[2].kind  = KIND_LED;
          bundle_o.res[2].red   = hit_rgb[2] ? led_level_i : 8'h00;
          bundle_o.res[2].green = hit_rgb[1] ? led_level_i : 8'h00;
          bundle_o.res[2].blue  = hit_rgb[0] ? led_level_i : 8'h00;
        end else begin
          bundle_o.res[2].kind = KIND_UNKNOWN;
        end
      end
      len_d      = '0;
      too_long_d = 1'b0;
    end else if (is_erase) begin
      if (len_q != '0) begin
        len_d                     = len_q - LEN_W'(1);
        bundle_o.cnt              = 2'd3;
        bundle_o.res[0].echo_byte = CHAR_BS;
        bundle_o.res[1].echo_byte = CHAR_SPACE;
        bundle_o.res[2].echo_byte = CHAR_BS;
      end
    end else if (is_print) begin
      if (len_q < LEN_W'(LINE_CAPACITY)) begin
        len_d                     = len_q + LEN_W'(1);
        store                     = 1'b1;
        bundle_o.cnt              = 2'd1;
        bundle_o.res[0].echo_byte = rx_byte_i;
      end else begin
        too_long_d = 1'b1;
      end
    end
    if (!req_valid_i) begin
      bundle_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      too_long_q <= 1'b0;
    end else if (advance_i) begin
      len_q      <= len_d;
      too_long_q <= too_long_d;
    end
  end

  // Characters past the prefix can never be part of a match and are not kept.
  always_ff @(posedge clk_i) begin
    if (advance_i && store && (len_q < LEN_W'(PREFIX_LEN))) begin
      chars_q[len_q[PREFIX_IDX_W-1:0]] <= rx_byte_i;
    end
  end

endmodule

// ===== rtl/sle_out.sv =====
// Result buffer: holds one bundle and hands its results out one at a time.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_out
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  bundle_t    bundle_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] echo_byte_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       last_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  bundle_t    bundle_q;
  result_t    cur;
  logic       take;

  assign cur         = bundle_q.res[idx_q];
  assign last_o      = (idx_q == (bundle_q.cnt - 2'd1));
  assign take        = valid_q && !out_stall_i;
  assign free_o      = !valid_q || (take && last_o);
  assign out_valid_o = valid_q;
  assign kind_o      = cur.kind;
  assign echo_byte_o = cur.echo_byte;
  assign red_o       = cur.red;
  assign green_o     = cur.green;
  assign blue_o      = cur.blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (take) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

// ===== rtl/serial_line_editor_command_match_unit.sv =====
// Serial line editor with command match: top level with input register and level register.
// A request's first result is offered once the result buffer has taken its bundle.
// Throughput: one request per cycle while each has at most one result and the output is
// not stalled; an erase holds the output for three results, a line end for two or three.
// Reset empties both stages, clears the line and the overflow mark and sets the level to 64.
// Depends on sle_pkg, sle_edit and sle_out.
`timescale 1ns / 1ps

module serial_line_editor_command_match_unit
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] echo_byte_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       last_o
);

  // The drive level register, written directly from the configuration port.
  logic [7:0] led_level_q;

  // Input register: one request waits here while its results are worked out.
  logic       req_valid_q;
  logic       command_q;
  logic [7:0] rx_byte_q;

  bundle_t    bundle;
  logic       buf_free;
  logic       advance;
  logic       load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_level_q <= LED_LEVEL_RESET;
    end else if (cfg_we_i) begin
      led_level_q <= cfg_wdata_i;
    end
  end

  // A request with no results retires at once, even while the buffer is still draining,
  // since it only changes the line state and adds nothing to the output order.
  // A request with results retires when the buffer takes its bundle, which may be in the
  // same cycle as the previous bundle's last result leaves.
  assign advance    = req_valid_q && ((bundle.cnt == 2'd0) || buf_free);
  assign load       = advance && (bundle.cnt != 2'd0);
  assign in_stall_o = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      command_q <= command_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  // Line state and decode; the state moves on only when the request retires.
  sle_edit u_edit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_q),
    .advance_i   (advance),
    .command_i   (command_q),
    .rx_byte_i   (rx_byte_q),
    .led_level_i (led_level_q),
    .bundle_o    (bundle)
  );

  // Result buffer, which parts the decode from the output handshake.
  sle_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .echo_byte_o (echo_byte_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_o)
  );

endmodule
